FILE: rtl/s2d_pkg.sv
// Shared constants, types and the BCD adjust function of the signed binary to decimal converter.
package s2d_pkg;

  localparam int VALUE_BITS    = 32;
  // decimal digits needed for 2**VALUE_BITS (log10(2) ~ 0.30103)
  localparam int DIGITS        = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int IDX_W         = $clog2(DIGITS);
  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_BITS      = STEPS * BITS_PER_STEP;
  localparam int CNT_W         = $clog2(STEPS + 1);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_MINUS = 8'd45;

  typedef logic [DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic             neg;
    logic [IDX_W-1:0] top;
    bcd_t             bcd;
  } conv_t;

  function automatic bcd_t bcd_adjust(bcd_t d);
    bcd_t r;
    r = d;
    for (int i = 0; i < DIGITS; i++) begin
      if (d[i] >= 4'd5) begin
        r[i] = d[i] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/s2d_front.sv
// Front end: accepts a request, takes sign and magnitude, converts to BCD by iterative double dabble.
module s2d_front (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic signed [s2d_pkg::VALUE_BITS-1:0]  value,
  input  logic                                   push,
  output logic                                   full,
  output logic                                   q_push,
  input  logic                                   q_full,
  output s2d_pkg::conv_t                         q_data
);
  import s2d_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_CONV = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t              state;
  logic [CNT_W-1:0]     cnt;
  logic                 neg;
  logic [PAD_BITS-1:0]  bin;
  bcd_t                 bcd;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [PAD_BITS-1:0]   bin_next;
  bcd_t                  bcd_next;
  logic [IDX_W-1:0]      top;

  assign raw = value;
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  always_comb begin
    bcd_next = bcd;
    bin_next = bin;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      bcd_next = bcd_adjust(bcd_next);
      {bcd_next, bin_next} = {bcd_next, bin_next} << 1;
    end
  end

  // most significant nonzero digit, zero gives digit 0
  always_comb begin
    top = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (push) begin
            neg   <= raw[VALUE_BITS-1];
            bin   <= PAD_BITS'(mag);
            bcd   <= '0;
            cnt   <= '0;
            state <= F_CONV;
          end
        end
        F_CONV: begin
          bin <= bin_next;
          bcd <= bcd_next;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(STEPS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  assign full   = (state != F_IDLE);
  assign q_push = (state == F_PUSH);
  assign q_data = '{neg: neg, top: top, bcd: bcd};

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> (full && state == F_CONV))
    else $error("front did not start conversion after request");

endmodule

FILE: rtl/s2d_queue.sv
// Two-entry queue between the converting front end and the character emitter.
module s2d_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  s2d_pkg::conv_t wdata,
  input  logic           pop,
  output logic           empty,
  output s2d_pkg::conv_t rdata
);
  import s2d_pkg::*;

  conv_t      slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= ~wptr;
      end
      if (do_pop) begin
        rptr <= ~rptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not grow on push");

  a_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wptr == rptr))
    else $error("queue pointers disagree with count");

endmodule

FILE: rtl/s2d_back.sv
// Back end: walks one converted entry and emits its sign and digits through an output register.
module s2d_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  output logic           q_pop,
  input  s2d_pkg::conv_t q_data,
  output logic [7:0]     char_code,
  output logic           last,
  output logic           empty,
  input  logic           pop
);
  import s2d_pkg::*;

  typedef enum logic [2:0] {
    B_IDLE  = 3'b001,
    B_SIGN  = 3'b010,
    B_DIGIT = 3'b100
  } bstate_t;

  bstate_t          state;
  conv_t            cur;
  logic [IDX_W-1:0] idx;
  logic             out_valid;
  logic             out_free;
  logic             emit;

  assign out_free = !out_valid || pop;
  assign emit     = (state != B_IDLE) && out_free;
  assign empty    = !out_valid;
  assign q_pop    = (state == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cur   <= q_data;
            idx   <= q_data.top;
            state <= q_data.neg ? B_SIGN : B_DIGIT;
          end
        end
        B_SIGN: begin
          if (out_free) begin
            char_code <= CH_MINUS;
            last      <= 1'b0;
            state     <= B_DIGIT;
          end
        end
        B_DIGIT: begin
          if (out_free) begin
            char_code <= CH_ZERO + {4'd0, cur.bcd[idx]};
            last      <= (idx == '0);
            if (idx == '0) begin
              state <= B_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |-> (char_code >= CH_ZERO && char_code <= CH_ZERO + 8'd9))
    else $error("final character is not a digit");

  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    (!empty && char_code == CH_MINUS) |-> (!last && state == B_DIGIT))
    else $error("minus sign out of place");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(char_code) && $stable(last)))
    else $error("output register changed while stalled");

endmodule

FILE: rtl/signed_binary_to_decimal_ascii_top.sv
// Signed binary to decimal ASCII converter: front end, queue and character emitter.
//
// Usage: write a signed 32-bit value with push while full is low. The block
// returns its decimal text one ASCII character per request on char_code,
// most significant first, with a leading '-' for negative values and no
// leading zeros; last marks the final character. A result is present while
// empty is low and is taken with pop.
// Operation: the front end runs its double dabble loop (4 bits a cycle),
// then hands the entry to the queue; the emitter loads the entry from the
// queue and then emits its sign and digits.
// Flow: the front end takes a new value only after it has handed the last
// one to the queue; the emitter emits all characters of one entry before it
// loads the next.
// A two-entry queue separates the front end from the emitter, and the output
// register holds the current character while pop is low; full is high while
// the front end converts a value or waits for room in the queue.
// Reset (rst, synchronous) empties the queue and the output register and
// drops any value in flight.
module signed_binary_to_decimal_ascii_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic signed [s2d_pkg::VALUE_BITS-1:0] value,
  input  logic                                  push,
  output logic                                  full,
  output logic [7:0]                            char_code,
  output logic                                  last,
  output logic                                  empty,
  input  logic                                  pop
);
  import s2d_pkg::*;

  logic  fq_push;
  logic  fq_full;
  conv_t fq_data;
  logic  qb_empty;
  logic  qb_pop;
  conv_t qb_data;

  s2d_front u_front (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .push   (push),
    .full   (full),
    .q_push (fq_push),
    .q_full (fq_full),
    .q_data (fq_data)
  );

  s2d_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_data),
    .pop   (qb_pop),
    .empty (qb_empty),
    .rdata (qb_data)
  );

  s2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (qb_empty),
    .q_pop     (qb_pop),
    .q_data    (qb_data),
    .char_code (char_code),
    .last      (last),
    .empty     (empty),
    .pop       (pop)
  );

endmodule

FILE: test/tb.sv
// Testbench for the signed binary to decimal ASCII converter.
module tb;
  import s2d_pkg::*;

  localparam int N_RANDOM    = 310;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  typedef struct {
    logic [VALUE_BITS-1:0] v;
    string                 txt;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic signed [VALUE_BITS-1:0] value = '0;
  logic                         push = 1'b0;
  logic                         full;
  logic [7:0]                   char_code;
  logic                         last;
  logic                         empty;
  logic                         pop = 1'b0;

  logic       burst = 1'b0;
  logic       hold_off = 1'b0;
  int         stall_left = 0;
  int         n_sent = 0;
  int         errs = 0;
  int         cycles = 0;
  text_char_t text_q[$];
  string      typed_q[$];

  signed_binary_to_decimal_ascii_top u_top (.*);

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // decimal text of one request, sign first, no leading zeros
  function automatic void add_decimal_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS:0] mag;
    logic [3:0]          digs[$];
    text_char_t          c;
    mag = raw[VALUE_BITS-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
    do begin
      digs.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (raw[VALUE_BITS-1]) begin
      c.code = CH_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    for (int i = 0; i < digs.size(); i++) begin
      c.code = CH_ZERO + 8'(digs[i]);
      c.last = (i == digs.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  function automatic logic [VALUE_BITS-1:0] rand_value();
    longint p, lo, hi, mag;
    int     n;
    case ($urandom_range(0, 3))
      0: begin
        return $urandom();
      end
      1: begin
        n = $urandom_range(1, 10);
        p = 1;
        repeat (n - 1) p = p * 10;
        lo = (n == 1) ? 0 : p;
        hi = p * 10 - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        mag = lo + longint'({32'h0, $urandom()} % (hi - lo + 1));
        return $urandom_range(0, 1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
      end
      2: begin
        mag = $urandom_range(0, 300);
        return $urandom_range(0, 1) ? VALUE_BITS'(-mag) : VALUE_BITS'(mag);
      end
      default: begin
        return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 15)
                                    : 32'h7FFF_FFFF - $urandom_range(0, 15);
      end
    endcase
  endfunction

  task automatic offer_value(input logic [VALUE_BITS-1:0] v, input string txt,
                             input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      value <= $urandom();
      repeat (gap) @(posedge clk);
    end
    typed_q.push_back(txt);
    push <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
  endtask

  always @(posedge clk) begin
    text_char_t c;
    string      txt;
    if (!rst) begin
      if (push && !full) begin
        txt = typed_q.pop_front();
        if (txt.len() != 0) begin
          for (int i = 0; i < txt.len(); i++) begin
            c.code = txt[i];
            c.last = (i == txt.len() - 1);
            text_q.push_back(c);
          end
        end else begin
          add_decimal_text(value);
        end
        n_sent++;
      end
      if (pop && !empty) begin
        if (text_q.size() == 0) begin
          $error("unexpected character: char_code %0d last %0b", char_code, last);
          errs++;
        end else begin
          c = text_q.pop_front();
          if (char_code !== c.code) begin
            $error("char_code: expected %0d, got %0d", c.code, char_code);
            errs++;
          end
          if (last !== c.last) begin
            $error("last: expected %0b, got %0b", c.last, last);
            errs++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if (!burst && $urandom_range(0, 2) == 0) stall_left <= pick_gap();
    end
  end

  // long receiver hold-off so the block backs up and raises full
  initial begin
    wait (n_sent >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** signed_binary_to_decimal_ascii_top: FAILED **");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[20];
    int       total;
    rows = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'hFFFF_FFFF,  "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{32'hFFFF_FFF6,  "-10"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{32'hC465_3600,  "-1000000000"},
      '{32'd100,        ""},
      '{32'd12345,      ""},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'd65535,      ""},
      '{32'hFFFF_0000,  ""},
      '{32'h7FFF_FFFE,  ""},
      '{32'hFFFF_FFF7,  ""}
    };
    total = 20 + N_RANDOM;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 20; i++) offer_value(rows[i].v, rows[i].txt, 1'b0);
    for (int i = 0; i < N_RANDOM; i++) begin
      burst <= (i >= 150 && i < 200);
      offer_value(rand_value(), "", i >= 150 && i < 200);
    end
    push <= 1'b0;
    while (n_sent < total || text_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errs == 0) begin
      $display("** signed_binary_to_decimal_ascii_top: PASSED **");
    end else begin
      $display("** signed_binary_to_decimal_ascii_top: FAILED **");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/s2d_pkg.sv
rtl/s2d_front.sv
rtl/s2d_queue.sv
rtl/s2d_back.sv
rtl/signed_binary_to_decimal_ascii_top.sv
test/tb.sv
